// ----- src/lps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types, constants and the phase tables of the lamp phase sequencer.
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int MODE_COUNT = 3;
    localparam int SLOT_COUNT = 7;
    localparam int REM_W      = 17;
    localparam int LOCK_W     = 15;
    localparam int UNIT_W     = 16;

    localparam logic [UNIT_W-1:0] UNIT_RESET = 16'd1000;

    localparam logic [1:0] MODE_LONG   = 2'd0;
    localparam logic [1:0] MODE_RED_YL = 2'd1;
    localparam logic [1:0] MODE_GR_RED = 2'd2;

    typedef enum logic [1:0] {
        LAMP_GREEN  = 2'd0,
        LAMP_YELLOW = 2'd1,
        LAMP_RED    = 2'd2
    } lamp_t;

    typedef struct packed {
        logic       green_on;
        logic       yellow_on;
        logic       red_on;
        logic [1:0] mode_now;
        logic [1:0] phase_now;
        logic       in_lockout;
    } lps_result_t;

    function automatic logic [1:0] mode_len(input logic [1:0] mode);
        unique case (mode)
            MODE_LONG:   mode_len = 2'd3;
            MODE_RED_YL: mode_len = 2'd2;
            MODE_GR_RED: mode_len = 2'd2;
            default:     mode_len = 2'd3;
        endcase
    endfunction

    function automatic logic [2:0] mode_base(input logic [1:0] mode);
        unique case (mode)
            MODE_LONG:   mode_base = 3'd0;
            MODE_RED_YL: mode_base = 3'd3;
            MODE_GR_RED: mode_base = 3'd5;
            default:     mode_base = 3'd0;
        endcase
    endfunction

    function automatic logic [2:0] slot_of(input logic [1:0] mode, input logic [1:0] phase);
        logic [1:0] ph;
        ph = (phase >= mode_len(mode)) ? 2'd0 : phase;
        slot_of = mode_base(mode) + {1'b0, ph};
    endfunction

    function automatic lamp_t slot_lamp(input logic [2:0] slot);
        unique case (slot)
            3'd0:    slot_lamp = LAMP_GREEN;
            3'd1:    slot_lamp = LAMP_YELLOW;
            3'd2:    slot_lamp = LAMP_RED;
            3'd3:    slot_lamp = LAMP_RED;
            3'd4:    slot_lamp = LAMP_YELLOW;
            3'd5:    slot_lamp = LAMP_GREEN;
            default: slot_lamp = LAMP_RED;
        endcase
    endfunction

    // first mode runs two units a phase, the others one
    function automatic logic [REM_W-1:0] default_of(input logic [2:0] slot,
                                                   input logic [UNIT_W-1:0] unit);
        if (slot < 3'd3)
            default_of = {unit, 1'b0};
        else
            default_of = {1'b0, unit};
    endfunction

    function automatic logic [1:0] mode_inc(input logic [1:0] mode);
        mode_inc = (mode >= 2'd2) ? 2'd0 : mode + 2'd1;
    endfunction

    function automatic logic [1:0] mode_dec(input logic [1:0] mode);
        mode_dec = (mode == 2'd0) ? 2'd2 : mode - 2'd1;
    endfunction

endpackage

// ----- src/lps_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_engine
// Sequencer state and the per-tick update: phase timing, press handling and
// the post-press lockout. Produces the result of the tick being taken.
// ----------------------------------------------------------------------------
module lps_engine
    import lps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tick,
    input  logic                 button_pressed,
    input  logic [UNIT_W-1:0]    unit_ticks,
    output lps_result_t          result
);

    logic [1:0]        mode_reg, mode_next;
    logic [1:0]        phase_reg [MODE_COUNT];
    logic [1:0]        phase_next [MODE_COUNT];
    logic [REM_W-1:0]  rem_reg [SLOT_COUNT];
    logic [REM_W-1:0]  rem_next [SLOT_COUNT];
    logic [REM_W-1:0]  elapsed_reg, elapsed_next;
    logic [LOCK_W-1:0] lock_reg, lock_next;

    logic [1:0]        cur_mode, prev_mode, cur_phase, prev_phase, out_phase;
    logic [2:0]        cur_slot, lamp_slot;
    logic [REM_W-1:0]  rem_cur, elapsed_inc;
    lamp_t             lamp;
    logic              hold;

    always_comb
    begin
        cur_mode  = (mode_reg >= 2'd3) ? MODE_LONG : mode_reg;
        prev_mode = mode_dec(cur_mode);
        unique case (cur_mode)
            MODE_RED_YL: cur_phase = phase_reg[1];
            MODE_GR_RED: cur_phase = phase_reg[2];
            default:     cur_phase = phase_reg[0];
        endcase
        unique case (prev_mode)
            MODE_RED_YL: prev_phase = phase_reg[1];
            MODE_GR_RED: prev_phase = phase_reg[2];
            default:     prev_phase = phase_reg[0];
        endcase
        cur_slot    = slot_of(cur_mode, cur_phase);
        rem_cur     = rem_reg[cur_slot];
        elapsed_inc = elapsed_reg + {{(REM_W-1){1'b0}}, 1'b1};
    end

    always_comb
    begin
        mode_next    = cur_mode;
        phase_next   = phase_reg;
        rem_next     = rem_reg;
        elapsed_next = elapsed_reg;
        lock_next    = lock_reg;
        hold         = 1'b0;
        lamp_slot    = cur_slot;
        if (lock_reg != '0)
        begin
            lamp_slot = slot_of(prev_mode, prev_phase);
            hold      = 1'b1;
            if (tick)
                lock_next = lock_reg - {{(LOCK_W-1){1'b0}}, 1'b1};
        end
        else if (button_pressed)
        begin
            hold = unit_ticks[UNIT_W-1:1] != '0;
            if (tick)
            begin
                rem_next[cur_slot] = (elapsed_reg <= rem_cur) ? rem_cur - elapsed_reg : '0;
                mode_next          = mode_inc(cur_mode);
                elapsed_next       = '0;
                lock_next          = unit_ticks[UNIT_W-1:1];
            end
        end
        else if (tick)
        begin
            if (elapsed_inc >= rem_cur)
            begin
                rem_next[cur_slot]   = default_of(cur_slot, unit_ticks);
                phase_next[cur_mode] = (cur_phase + 2'd1 >= mode_len(cur_mode)) ?
                                       2'd0 : cur_phase + 2'd1;
                elapsed_next         = '0;
            end
            else
            begin
                elapsed_next = elapsed_inc;
            end
        end
        lamp = slot_lamp(lamp_slot);
    end

    always_comb
    begin
        unique case (mode_next)
            MODE_RED_YL: out_phase = phase_next[1];
            MODE_GR_RED: out_phase = phase_next[2];
            default:     out_phase = phase_next[0];
        endcase
        result.green_on   = lamp == LAMP_GREEN;
        result.yellow_on  = lamp == LAMP_YELLOW;
        result.red_on     = lamp == LAMP_RED;
        result.mode_now   = mode_next;
        result.phase_now  = out_phase;
        result.in_lockout = hold;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_LONG;
            elapsed_reg <= '0;
            lock_reg    <= '0;
            for (int i = 0; i < MODE_COUNT; i++)
                phase_reg[i] <= 2'd0;
            for (int i = 0; i < SLOT_COUNT; i++)
                rem_reg[i] <= default_of(3'(i), UNIT_RESET);
        end
        else
        begin
            mode_reg    <= mode_next;
            phase_reg   <= phase_next;
            rem_reg     <= rem_next;
            elapsed_reg <= elapsed_next;
            lock_reg    <= lock_next;
        end
    end

    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != 2'd3)
        else $error("mode index out of range");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg[0] != 2'd3 && phase_reg[1] <= 2'd1 && phase_reg[2] <= 2'd1)
        else $error("saved phase out of range");

    a_lock_holds_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (tick && lock_reg != '0) |=> $stable(mode_reg) && $stable(elapsed_reg))
        else $error("mode or elapsed time moved during lockout");

    a_one_lamp: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({result.green_on, result.yellow_on, result.red_on}))
        else $error("lamp drive not one-hot");

endmodule

// ----- src/lamp_phase_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lamp_phase_sequencer
// Three-lamp phase sequencer, one request per millisecond tick.
// ----------------------------------------------------------------------------
// Each request is one tick carrying the button level and returns one result
// with the lamp drives, the selected mode, its saved phase and the lockout
// flag. A request is taken every clock unless stalled: the whole update is
// one pass of compare and subtract logic on the state registers, and the
// result lands in an output register. A new request is taken while the result
// is being collected; only a stalled, still-held result holds off the input.
// unit_ticks is written through cfg_wr_en / cfg_wr_data and resets to 1000.
module lamp_phase_sequencer
    import lps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [UNIT_W-1:0] cfg_wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              button_pressed,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              green_on,
    output logic              yellow_on,
    output logic              red_on,
    output logic [1:0]        mode_now,
    output logic [1:0]        phase_now,
    output logic              in_lockout
);

    logic [UNIT_W-1:0] unit_reg;
    logic              out_valid_reg, out_valid_next;
    lps_result_t       result_reg, step_result;
    logic              tick;

    assign in_stall = out_valid_reg && out_stall;
    assign tick     = in_valid && !in_stall;

    lps_engine u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick           (tick),
        .button_pressed (button_pressed),
        .unit_ticks     (unit_reg),
        .result         (step_result)
    );

    always_comb
    begin
        if (tick)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg      <= UNIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                unit_reg <= cfg_wr_data;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick)
            result_reg <= step_result;
    end

    assign out_valid  = out_valid_reg;
    assign green_on   = result_reg.green_on;
    assign yellow_on  = result_reg.yellow_on;
    assign red_on     = result_reg.red_on;
    assign mode_now   = result_reg.mode_now;
    assign phase_now  = result_reg.phase_now;
    assign in_lockout = result_reg.in_lockout;

endmodule

// ----- test/lamp_phase_sequencer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lamp_phase_sequencer_tb
// Self-checking bench for the three-lamp phase sequencer.
// ----------------------------------------------------------------------------
// Tick requests are sent through the valid/stall handshake with set or random
// button levels and random gaps on both sides. A local copy of the mode, saved
// phases, remaining times and lockout works out the expected lamps for each
// accepted request, and each result is compared field by field in order.
// unit_ticks is changed between phases only, with the queue drained. The run
// covers the reset unit, units of zero and one, small units for deep phase
// and lockout coverage, a long receiver hold-off and the largest unit.
module lamp_phase_sequencer_tb
    import lps_pkg::*;
();

    localparam int LIMIT = 200000;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [UNIT_W-1:0] cfg_wr_data;
    logic              in_valid;
    logic              in_stall;
    logic              button_pressed;
    logic              out_valid;
    logic              out_stall;
    logic              green_on;
    logic              yellow_on;
    logic              red_on;
    logic [1:0]        mode_now;
    logic [1:0]        phase_now;
    logic              in_lockout;

    // local copy of the sequencer state
    logic [UNIT_W-1:0] unit_len;
    logic [1:0]        lamp_mode;
    logic [1:0]        lamp_phase [MODE_COUNT];
    logic [REM_W-1:0]  time_left [SLOT_COUNT];
    logic [REM_W-1:0]  ticks_in_phase;
    logic [LOCK_W-1:0] hold_left;

    lps_result_t expected_lamps [$];
    lps_result_t seen_lamps;
    lps_result_t due_lamps;

    int  mismatches = 0;
    int  cycle_count = 0;
    int  press_run = 0;
    int  hold_request = 0;
    bit  tx_idle = 1'b0;
    bit  rx_idle = 1'b0;

    lamp_phase_sequencer DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .button_pressed (button_pressed),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .green_on       (green_on),
        .yellow_on      (yellow_on),
        .red_on         (red_on),
        .mode_now       (mode_now),
        .phase_now      (phase_now),
        .in_lockout     (in_lockout)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int phase_total(input logic [1:0] mode);
        case (mode)
            MODE_LONG:   phase_total = 3;
            MODE_RED_YL: phase_total = 2;
            default:     phase_total = 2;
        endcase
    endfunction

    function automatic int slot_in(input logic [1:0] mode);
        int ph;
        int first;
        ph = int'(lamp_phase[mode]);
        if (ph >= phase_total(mode))
            ph = 0;
        case (mode)
            MODE_LONG:   first = 0;
            MODE_RED_YL: first = 3;
            default:     first = 5;
        endcase
        slot_in = first + ph;
    endfunction

    function automatic lamp_t lamp_of(input int slot);
        case (slot)
            0, 5:    lamp_of = LAMP_GREEN;
            1, 4:    lamp_of = LAMP_YELLOW;
            default: lamp_of = LAMP_RED;
        endcase
    endfunction

    function automatic logic [REM_W-1:0] full_time(input int slot);
        logic [REM_W-1:0] t;
        t = {1'b0, unit_len};
        full_time = (slot < 3) ? t + t : t;
    endfunction

    function automatic lps_result_t predict_tick(input logic press);
        lamp_t       lamp;
        logic        hold;
        int          slot;
        int          nxt;
        logic [1:0]  back;
        lps_result_t r;
        hold = 1'b0;
        if (hold_left != 0)
        begin
            back = (lamp_mode == MODE_LONG) ? MODE_GR_RED : lamp_mode - 2'd1;
            lamp = lamp_of(slot_in(back));
            hold_left = hold_left - {{(LOCK_W-1){1'b0}}, 1'b1};
            hold = 1'b1;
        end
        else
        begin
            slot = slot_in(lamp_mode);
            lamp = lamp_of(slot);
            if (press)
            begin
                time_left[slot] = (ticks_in_phase <= time_left[slot]) ?
                                  time_left[slot] - ticks_in_phase : '0;
                lamp_mode = (lamp_mode == MODE_GR_RED) ? MODE_LONG : lamp_mode + 2'd1;
                ticks_in_phase = '0;
                hold_left = unit_len[UNIT_W-1:1];
                hold = (hold_left != 0);
            end
            else
            begin
                ticks_in_phase = ticks_in_phase + {{(REM_W-1){1'b0}}, 1'b1};
                if (ticks_in_phase >= time_left[slot])
                begin
                    time_left[slot] = full_time(slot);
                    nxt = lamp_phase[lamp_mode] + 1;
                    lamp_phase[lamp_mode] = (nxt >= phase_total(lamp_mode)) ? 2'd0 : nxt[1:0];
                    ticks_in_phase = '0;
                end
            end
        end
        r.green_on   = (lamp == LAMP_GREEN);
        r.yellow_on  = (lamp == LAMP_YELLOW);
        r.red_on     = (lamp == LAMP_RED);
        r.mode_now   = lamp_mode;
        r.phase_now  = lamp_phase[lamp_mode];
        r.in_lockout = hold;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_lamps.push_back(predict_tick(button_pressed));
            if (out_valid && !out_stall)
            begin
                seen_lamps = {green_on, yellow_on, red_on, mode_now, phase_now, in_lockout};
                if (expected_lamps.size() == 0)
                begin
                    $display("%0t: result with no request waiting, expected none, actual %b",
                             $time, seen_lamps);
                    mismatches++;
                end
                else
                begin
                    due_lamps = expected_lamps.pop_front();
                    check_field("green_on", due_lamps.green_on, seen_lamps.green_on);
                    check_field("yellow_on", due_lamps.yellow_on, seen_lamps.yellow_on);
                    check_field("red_on", due_lamps.red_on, seen_lamps.red_on);
                    check_field("mode_now", due_lamps.mode_now, seen_lamps.mode_now);
                    check_field("phase_now", due_lamps.phase_now, seen_lamps.phase_now);
                    check_field("in_lockout", due_lamps.in_lockout, seen_lamps.in_lockout);
                end
            end
            if (cfg_wr_en)
                unit_len = cfg_wr_data;
        end
    end

    // result side: random stall per result, or a long hold-off on request
    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            if (hold_request > 0)
            begin
                gap = hold_request;
                hold_request = 0;
            end
            else
                gap = rx_idle ? $urandom_range(0, 11) : 0;
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    task automatic send_tick(input logic press);
        int gap;
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        button_pressed <= press;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_lamps.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_unit(input logic [UNIT_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_pattern(input logic [15:0] presses, input int count);
        for (int i = 0; i < count; i++)
            send_tick(presses[i]);
    endtask

    function automatic logic draw_button();
        if (press_run > 0)
        begin
            press_run--;
            return 1'b1;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            press_run = $urandom_range(0, 3);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic test_power_up;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_pattern(16'b0000, 2);
        drain();
    endtask

    // press after two ticks, held through the lockout and counted again after it
    task automatic test_press_and_lockout;
        set_unit(16'd4);
        send_pattern(16'b0000_0011_1100, 10);
        drain();
    endtask

    task automatic test_tiny_units;
        set_unit(16'd1);
        send_pattern(16'b00111, 5);
        drain();
        set_unit(16'd0);
        send_pattern(16'b01000, 5);
        drain();
    endtask

    task automatic test_random_units;
        logic [UNIT_W-1:0] u;
        for (int k = 0; k < 8; k++)
        begin
            case (k)
                0:       u = 16'd2;
                1:       u = 16'd3;
                2:       u = 16'd5;
                3:       u = 16'd1;
                4:       u = 16'd0;
                5:       u = UNIT_W'($urandom_range(6, 16));
                6:       u = 16'd2;
                default: u = UNIT_W'($urandom_range(2, 40));
            endcase
            set_unit(u);
            tx_idle = ($urandom_range(0, 2) != 0);
            rx_idle = ($urandom_range(0, 2) != 0);
            press_run = 0;
            for (int i = 0; i < 70; i++)
                send_tick(draw_button());
            drain();
        end
    endtask

    // receiver holds off while requests keep coming, so the input backs up
    task automatic test_receiver_hold_off;
        set_unit(UNIT_W'($urandom_range(2, 6)));
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        hold_request = 300;
        for (int i = 0; i < 60; i++)
            send_tick(draw_button());
        drain();
    endtask

    task automatic test_largest_unit;
        set_unit(16'hFFFF);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_pattern(16'b01100, 5);
        drain();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        in_valid       = 1'b0;
        button_pressed = 1'b0;
        out_stall      = 1'b0;
        unit_len       = UNIT_RESET;
        lamp_mode      = MODE_LONG;
        ticks_in_phase = '0;
        hold_left      = '0;
        for (int m = 0; m < MODE_COUNT; m++)
            lamp_phase[m] = 2'd0;
        for (int s = 0; s < SLOT_COUNT; s++)
            time_left[s] = full_time(s);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_up();
        test_press_and_lockout();
        test_tiny_units();
        test_random_units();
        test_receiver_hold_off();
        test_largest_unit();

        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_lamps.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
